@@ design/fasp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasp_pkg
// Types, event codes and constants shared by the activity stream parser.
// ----------------------------------------------------------------------------
package fasp_pkg;

  localparam int LOCAL_TYPES     = 16;
  localparam int LT_W            = 4;
  localparam int MAX_FIELDS_DEF  = 128;
  localparam int MIN_HDR_LEN     = 12;

  localparam logic [7:0] DEF_BIT_MASK = 8'h40;
  localparam logic [7:0] LT_MASK      = 8'h0F;

  localparam logic [15:0] GLOBAL_RECORD  = 16'd20;
  localparam logic [15:0] GLOBAL_SESSION = 16'd18;
  localparam logic [15:0] GLOBAL_LAP     = 16'd19;

  localparam logic [7:0] FLD_TIMESTAMP = 8'd253;
  localparam logic [7:0] FLD_ENH_ALT   = 8'd78;

  localparam logic [4:0] EV_ROW       = 5'd0;
  localparam logic [4:0] EV_ALT16     = 5'd1;
  localparam logic [4:0] EV_ENH_ALT   = 5'd2;
  localparam logic [4:0] EV_REC_TIME  = 5'd3;
  localparam logic [4:0] EV_SES_START = 5'd4;
  localparam logic [4:0] EV_SPORT     = 5'd5;
  localparam logic [4:0] EV_SES_DUR   = 5'd6;
  localparam logic [4:0] EV_SES_DIST  = 5'd7;
  localparam logic [4:0] EV_LAPS      = 5'd8;
  localparam logic [4:0] EV_LAP_TIME  = 5'd9;
  localparam logic [4:0] EV_LAP_START = 5'd10;
  localparam logic [4:0] EV_LAP_DUR   = 5'd11;
  localparam logic [4:0] EV_LAP_DIST  = 5'd12;
  localparam logic [4:0] EV_NOT_FIT   = 5'd13;
  localparam logic [4:0] EV_NO_DEF    = 5'd14;
  localparam logic [4:0] EV_TOO_MANY  = 5'd15;
  localparam logic [4:0] EV_TRUNC     = 5'd16;

  typedef enum logic [1:0] {
    CLS_OTHER   = 2'd0,
    CLS_RECORD  = 2'd1,
    CLS_SESSION = 2'd2,
    CLS_LAP     = 2'd3
  } msg_class_t;

  typedef enum logic [3:0] {
    PH_HDR   = 4'd0,
    PH_SKIP  = 4'd1,
    PH_MSG   = 4'd2,
    PH_DRES  = 4'd3,
    PH_DARCH = 4'd4,
    PH_DGLO  = 4'd5,
    PH_DGHI  = 4'd6,
    PH_DCNT  = 4'd7,
    PH_DFLD  = 4'd8,
    PH_DATA  = 4'd9,
    PH_IDLE  = 4'd10
  } phase_t;

  // Everything one byte produced: up to two results.
  typedef struct packed {
    logic        has0;
    logic [4:0]  ev0;
    logic [31:0] val0;
    logic        has1;
    logic [4:0]  ev1;       // row or truncated
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] dist_cm;
    logic [7:0]  hr;
  } bundle_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h2E;
      2'd1:    r = 8'h46;
      2'd2:    r = 8'h49;
      default: r = 8'h54;
    endcase
    return r;
  endfunction

endpackage

@@ design/fasp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasp_in_if
// Byte channel into the parser.
// ----------------------------------------------------------------------------
interface fasp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;
  logic       file_end;

  modport source (output valid, data_byte, file_start, file_end, input ready);
  modport sink   (input valid, data_byte, file_start, file_end, output ready);
endinterface

@@ design/fasp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasp_out_if
// Event channel out of the parser.
// ----------------------------------------------------------------------------
interface fasp_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         event_res;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic [31:0]        distance_cm;
  logic [7:0]         heart_rate;
  logic [31:0]        field_value;
  logic               last_of_run;

  modport source (output valid, event_res, latitude, longitude, distance_cm, heart_rate,
                  field_value, last_of_run, input ready);
  modport sink   (input valid, event_res, latitude, longitude, distance_cm, heart_rate,
                  field_value, last_of_run, output ready);
endinterface

@@ design/fasp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasp_front
// Byte parser: header, definitions, data fields. Emits at most one bundle per byte.
// ----------------------------------------------------------------------------
module fasp_front #(
  parameter int MAX_FIELDS = fasp_pkg::MAX_FIELDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fasp_in_if.sink           feed,
  input  logic              q_full,
  output logic              push,
  output fasp_pkg::bundle_t bundle
);

  localparam int DEPTH = fasp_pkg::LOCAL_TYPES * MAX_FIELDS;
  localparam int AW    = $clog2(DEPTH);

  // field table: only non-empty fields are stored, packed in order
  logic [15:0] mem [DEPTH];
  logic [15:0] rd;

  fasp_pkg::phase_t   phase, phase_next;
  logic [31:0] offset, offset_next;
  logic [31:0] end_offs, end_offs_next;
  logic [7:0]  hdr_len, hdr_len_next;
  logic [3:0]  lt_now, lt_now_next;
  logic [7:0]  cursor, cursor_next;
  logic [7:0]  bif, bif_next;
  logic [31:0] asm_r, asm_next;
  logic [31:0] row_lat, row_lat_next, row_lon, row_lon_next, row_dist, row_dist_next;
  logic [7:0]  row_hr, row_hr_next;
  logic [2:0]  flags, flags_next;
  logic [7:0]  cnt_now, cnt_now_next;
  logic [7:0]  nec, nec_next;

  logic [fasp_pkg::LOCAL_TYPES-1:0] valid, valid_next, hasf;
  fasp_pkg::msg_class_t cls [fasp_pkg::LOCAL_TYPES];
  logic [7:0]           necnt [fasp_pkg::LOCAL_TYPES];

  logic        fire;
  logic        we, re, def_open, fld_add;
  logic [AW-1:0] wa, ra;
  logic [15:0] wd;
  fasp_pkg::msg_class_t cls_new;

  logic        start;
  logic [7:0]  b;
  fasp_pkg::phase_t ph;
  logic [31:0] o, de;
  logic [7:0]  hl, cur, bf;
  logic [31:0] a0, an;
  logic [32:0] sum, nxt;
  logic [7:0]  sz, fi;
  logic [15:0] glob;

  assign feed.ready = !q_full;
  assign fire       = feed.valid && !q_full;
  assign push       = fire && (bundle.has0 || bundle.has1);

  function automatic logic [AW-1:0] addr(input logic [3:0] lt, input logic [7:0] idx);
    return AW'(lt) * AW'(MAX_FIELDS) + AW'(idx);
  endfunction

  always_comb begin
    b     = feed.data_byte;
    start = feed.file_start;
    ph    = start ? fasp_pkg::PH_HDR : phase;
    o     = start ? 32'd0 : offset;
    de    = start ? 32'd0 : end_offs;
    hl    = start ? 8'd0 : hdr_len;
    cur   = start ? 8'd0 : cursor;
    bf    = start ? 8'd0 : bif;
    a0    = start ? 32'd0 : asm_r;

    phase_next    = ph;
    offset_next   = (o == 32'hFFFF_FFFF) ? o : o + 32'd1;
    end_offs_next = de;
    hdr_len_next  = hl;
    lt_now_next   = lt_now;
    cursor_next   = cur;
    bif_next      = bf;
    asm_next      = a0;
    row_lat_next  = row_lat;
    row_lon_next  = row_lon;
    row_dist_next = row_dist;
    row_hr_next   = row_hr;
    flags_next    = flags;
    cnt_now_next  = cnt_now;
    nec_next      = nec;
    valid_next    = start ? '0 : valid;

    we = 1'b0; re = 1'b0; def_open = 1'b0; fld_add = 1'b0;
    wa = '0; ra = '0; wd = '0;
    cls_new = fasp_pkg::CLS_OTHER;
    sum = '0; nxt = '0; an = '0; glob = '0;
    sz = rd[15:8];
    fi = rd[7:0];

    bundle      = '0;
    bundle.ev0  = fasp_pkg::EV_ROW;
    bundle.ev1  = fasp_pkg::EV_ROW;

    case (ph)
      fasp_pkg::PH_HDR: begin
        if (o == 32'd0) begin
          hdr_len_next = (b < 8'(fasp_pkg::MIN_HDR_LEN)) ? 8'(fasp_pkg::MIN_HDR_LEN) : b;
        end else if (o >= 32'd4 && o <= 32'd7) begin
          case (o[1:0])
            2'd0:    asm_next = {24'd0, b};
            2'd1:    asm_next = {a0[31:16], b, a0[7:0]};
            2'd2:    asm_next = {a0[31:24], b, a0[15:0]};
            default: asm_next = {b, a0[23:0]};
          endcase
          if (o == 32'd7) begin
            sum = 33'(hl) + 33'({b, a0[23:0]});
            end_offs_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
        end else if (o >= 32'd8 && o <= 32'd11) begin
          if (b != fasp_pkg::sig_byte(o[1:0])) begin
            bundle.has0 = 1'b1;
            bundle.ev0  = fasp_pkg::EV_NOT_FIT;
            phase_next  = fasp_pkg::PH_IDLE;
          end else if (o == 32'd11) begin
            phase_next = (hl > 8'(fasp_pkg::MIN_HDR_LEN)) ? fasp_pkg::PH_SKIP
                                                         : fasp_pkg::PH_MSG;
          end
        end
      end
      fasp_pkg::PH_SKIP: begin
        if (33'(o) + 33'd1 >= 33'(hl)) phase_next = fasp_pkg::PH_MSG;
      end
      fasp_pkg::PH_MSG: begin
        lt_now_next = b[3:0];
        if ((b & fasp_pkg::DEF_BIT_MASK) != 8'd0) begin
          phase_next = fasp_pkg::PH_DRES;
        end else if (!valid_next[b[3:0]]) begin
          bundle.has0 = 1'b1;
          bundle.ev0  = fasp_pkg::EV_NO_DEF;
          phase_next  = fasp_pkg::PH_IDLE;
        end else begin
          cursor_next = 8'd0; bif_next = 8'd0;
          row_lat_next = '0; row_lon_next = '0; row_dist_next = '0;
          row_hr_next = '0; flags_next = '0;
          if (hasf[b[3:0]]) begin
            phase_next = fasp_pkg::PH_DATA;
            re = 1'b1;
            ra = addr(b[3:0], 8'd0);
          end else begin
            phase_next = fasp_pkg::PH_MSG;
          end
        end
      end
      fasp_pkg::PH_DRES:  phase_next = fasp_pkg::PH_DARCH;
      fasp_pkg::PH_DARCH: phase_next = fasp_pkg::PH_DGLO;
      fasp_pkg::PH_DGLO: begin
        asm_next   = {24'd0, b};
        phase_next = fasp_pkg::PH_DGHI;
      end
      fasp_pkg::PH_DGHI: begin
        asm_next   = {16'd0, b, a0[7:0]};
        phase_next = fasp_pkg::PH_DCNT;
      end
      fasp_pkg::PH_DCNT: begin
        if ({1'b0, b} > 9'(MAX_FIELDS)) begin
          bundle.has0 = 1'b1;
          bundle.ev0  = fasp_pkg::EV_TOO_MANY;
          phase_next  = fasp_pkg::PH_IDLE;
        end else begin
          glob = a0[15:0];
          if (glob == fasp_pkg::GLOBAL_RECORD)       cls_new = fasp_pkg::CLS_RECORD;
          else if (glob == fasp_pkg::GLOBAL_SESSION) cls_new = fasp_pkg::CLS_SESSION;
          else if (glob == fasp_pkg::GLOBAL_LAP)     cls_new = fasp_pkg::CLS_LAP;
          def_open = 1'b1;
          valid_next[lt_now] = 1'b1;
          cnt_now_next = b;
          nec_next = 8'd0;
          cursor_next = 8'd0; bif_next = 8'd0;
          phase_next = (b == 8'd0) ? fasp_pkg::PH_MSG : fasp_pkg::PH_DFLD;
        end
      end
      fasp_pkg::PH_DFLD: begin
        if (bf == 8'd0) begin
          asm_next = {24'd0, b};
          bif_next = 8'd1;
        end else if (bf == 8'd1) begin
          if (b != 8'd0) begin
            we = 1'b1;
            wa = addr(lt_now, nec);
            wd = {b, a0[7:0]};
            nec_next = nec + 8'd1;
            fld_add = 1'b1;
          end
          bif_next = 8'd2;
        end else begin
          bif_next = 8'd0;
          cursor_next = cur + 8'd1;
          if (9'(cur) + 9'd1 >= 9'(cnt_now)) phase_next = fasp_pkg::PH_MSG;
        end
      end
      fasp_pkg::PH_DATA: begin
        if (bf == 8'd0)     an = {24'd0, b};
        else if (bf < 8'd4) an = a0 | (32'(b) << {bf[1:0], 3'b000});
        else                an = a0;
        asm_next = an;
        bif_next = bf + 8'd1;
        if (9'(bf) + 9'd1 >= 9'(sz)) begin
          bif_next = 8'd0;
          cursor_next = cur + 8'd1;
          case (cls[lt_now])
            fasp_pkg::CLS_RECORD: begin
              if (sz == 8'd4) begin
                if (fi == 8'd0) begin
                  row_lat_next = an; flags_next[0] = 1'b1;
                end else if (fi == 8'd1) begin
                  row_lon_next = an; flags_next[1] = 1'b1;
                end else if (fi == 8'd5) begin
                  row_dist_next = an;
                end else if (fi == fasp_pkg::FLD_ENH_ALT) begin
                  bundle.has0 = 1'b1; bundle.ev0 = fasp_pkg::EV_ENH_ALT; bundle.val0 = an;
                end else if (fi == fasp_pkg::FLD_TIMESTAMP) begin
                  bundle.has0 = 1'b1; bundle.ev0 = fasp_pkg::EV_REC_TIME; bundle.val0 = an;
                end
              end else if (sz == 8'd1) begin
                if (fi == 8'd3) begin
                  row_hr_next = an[7:0]; flags_next[2] = 1'b1;
                end
              end else if (sz == 8'd2) begin
                if (fi == 8'd2) begin
                  bundle.has0 = 1'b1; bundle.ev0 = fasp_pkg::EV_ALT16;
                  bundle.val0 = {16'd0, an[15:0]};
                end
              end
            end
            fasp_pkg::CLS_SESSION: begin
              bundle.has0 = 1'b1;
              bundle.val0 = an;
              if (fi == 8'd2)       bundle.ev0 = fasp_pkg::EV_SES_START;
              else if (fi == 8'd5) begin
                bundle.ev0 = fasp_pkg::EV_SPORT; bundle.val0 = {24'd0, an[7:0]};
              end
              else if (fi == 8'd8)  bundle.ev0 = fasp_pkg::EV_SES_DUR;
              else if (fi == 8'd9)  bundle.ev0 = fasp_pkg::EV_SES_DIST;
              else if (fi == 8'd26) begin
                bundle.ev0 = fasp_pkg::EV_LAPS; bundle.val0 = {16'd0, an[15:0]};
              end
              else bundle.has0 = 1'b0;
            end
            fasp_pkg::CLS_LAP: begin
              bundle.has0 = 1'b1;
              bundle.val0 = an;
              if (fi == fasp_pkg::FLD_TIMESTAMP) bundle.ev0 = fasp_pkg::EV_LAP_TIME;
              else if (fi == 8'd2)               bundle.ev0 = fasp_pkg::EV_LAP_START;
              else if (fi == 8'd8)               bundle.ev0 = fasp_pkg::EV_LAP_DUR;
              else if (fi == 8'd9)               bundle.ev0 = fasp_pkg::EV_LAP_DIST;
              else bundle.has0 = 1'b0;
            end
            default: ;
          endcase
          if (9'(cur) + 9'd1 >= 9'(necnt[lt_now])) begin
            // message done: row if both coordinates were seen
            if (cls[lt_now] == fasp_pkg::CLS_RECORD && flags_next[1:0] == 2'b11) begin
              bundle.has1 = 1'b1;
              bundle.ev1  = fasp_pkg::EV_ROW;
            end
            phase_next = fasp_pkg::PH_MSG;
          end else begin
            re = 1'b1;
            ra = addr(lt_now, cur + 8'd1);
          end
        end
      end
      default: phase_next = fasp_pkg::PH_IDLE;
    endcase

    if (phase_next != fasp_pkg::PH_IDLE) begin
      nxt = 33'(o) + 33'd1;
      if (feed.file_end) begin
        if (phase_next == fasp_pkg::PH_HDR) begin
          bundle.has1 = 1'b1;
          bundle.ev1  = fasp_pkg::EV_TRUNC;
          phase_next  = fasp_pkg::PH_IDLE;
        end else if (nxt < 33'(end_offs_next)) begin
          end_offs_next = nxt[31:0];
        end
      end
      if (phase_next != fasp_pkg::PH_IDLE && phase_next != fasp_pkg::PH_HDR &&
          nxt >= 33'(end_offs_next)) begin
        if (phase_next != fasp_pkg::PH_SKIP && phase_next != fasp_pkg::PH_MSG) begin
          bundle.has1 = 1'b1;
          bundle.ev1  = fasp_pkg::EV_TRUNC;
        end
        phase_next = fasp_pkg::PH_IDLE;
      end
    end

    bundle.lat     = row_lat_next;
    bundle.lon     = row_lon_next;
    bundle.dist_cm = row_dist_next;
    bundle.hr      = row_hr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= fasp_pkg::PH_HDR;
      offset   <= '0;
      end_offs <= '0;
      hdr_len  <= '0;
      lt_now   <= '0;
      cursor   <= '0;
      bif      <= '0;
      asm_r    <= '0;
      row_lat  <= '0;
      row_lon  <= '0;
      row_dist <= '0;
      row_hr   <= '0;
      flags    <= '0;
      cnt_now  <= '0;
      nec      <= '0;
      valid    <= '0;
      hasf     <= '0;
    end else if (fire) begin
      phase    <= phase_next;
      offset   <= offset_next;
      end_offs <= end_offs_next;
      hdr_len  <= hdr_len_next;
      lt_now   <= lt_now_next;
      cursor   <= cursor_next;
      bif      <= bif_next;
      asm_r    <= asm_next;
      row_lat  <= row_lat_next;
      row_lon  <= row_lon_next;
      row_dist <= row_dist_next;
      row_hr   <= row_hr_next;
      flags    <= flags_next;
      cnt_now  <= cnt_now_next;
      nec      <= nec_next;
      valid    <= valid_next;
      if (def_open)     hasf[lt_now] <= 1'b0;
      else if (fld_add) hasf[lt_now] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && def_open) begin
      cls[lt_now]   <= cls_new;
      necnt[lt_now] <= 8'd0;
    end else if (fire && fld_add) begin
      necnt[lt_now] <= nec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && we) mem[wa] <= wd;
    if (fire && re) rd <= mem[ra];
  end

endmodule

@@ design/fasp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasp_queue
// Two-entry queue of per-byte bundles between parser and output stage.
// ----------------------------------------------------------------------------
module fasp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fasp_pkg::bundle_t din,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output fasp_pkg::bundle_t head
);

  fasp_pkg::bundle_t slot [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
                                (count == 2'd0 || count == 2'd2) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

endmodule

@@ design/fasp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasp_back
// Splits each bundle into one or two result items on the output channel.
// ----------------------------------------------------------------------------
module fasp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              nonempty,
  input  fasp_pkg::bundle_t head,
  output logic              pop,
  fasp_out_if.source        result
);

  logic second;
  logic use0, fire;

  assign use0 = head.has0 && !second;
  assign fire = result.valid && result.ready;
  assign pop  = fire && !(use0 && head.has1);

  always_comb begin
    result.valid       = nonempty;
    result.latitude    = '0;
    result.longitude   = '0;
    result.distance_cm = '0;
    result.heart_rate  = '0;
    result.field_value = '0;
    if (use0) begin
      result.event_res   = head.ev0;
      result.field_value = head.val0;
      result.last_of_run = !head.has1;
    end else begin
      result.event_res   = head.ev1;
      result.last_of_run = 1'b1;
      if (head.ev1 == fasp_pkg::EV_ROW) begin
        result.latitude    = $signed(head.lat);
        result.longitude   = $signed(head.lon);
        result.distance_cm = head.dist_cm;
        result.heart_rate  = head.hr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (fire) begin
      second <= use0 && head.has1;
    end
  end

  a_second_needs_pair: assert property (@(posedge clk) disable iff (rst)
                                        second |-> (nonempty && head.has0 && head.has1))
    else $error("second half without a two-item bundle");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
                                  pop |-> result.last_of_run)
    else $error("bundle released before its last item");
  a_nonempty_bundle: assert property (@(posedge clk) disable iff (rst)
                                      nonempty |-> (head.has0 || head.has1))
    else $error("empty bundle in queue");

endmodule

@@ design/fit_activity_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_activity_stream_parser
// FIT activity file decoder: one file byte in, raw record/session/lap events out.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock while the queue is not full, with no gaps
// needed between bytes. Each byte is handled by the front parser, which reads its
// field table (a one-port memory with registered read, prefetched one byte ahead).
// Results leave one per cycle while the output is ready; a byte that yields two
// results (a field event followed by a row, or an event followed by truncated)
// occupies the output for both items, and a two-entry queue lets the parser keep
// taking bytes during that. An accepted byte's results are registered in the
// queue before they reach the output. No clearing pass is needed after reset.
module fit_activity_stream_parser #(
  parameter int MAX_FIELDS = fasp_pkg::MAX_FIELDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fasp_in_if.sink     feed,
  fasp_out_if.source  result
);

  fasp_pkg::bundle_t bundle, head;
  logic push, pop, full, nonempty;

  fasp_front #(.MAX_FIELDS(MAX_FIELDS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .q_full (full),
    .push   (push),
    .bundle (bundle)
  );

  fasp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (bundle),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  fasp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .result   (result)
  );

endmodule
